// File: hdl/rgbconv_pkg.sv
// ----------------------------------------------------------------------------
// rgbconv_pkg
// Shared types and fixed field widths for the RGB streaming convolution.
// ----------------------------------------------------------------------------
package rgbconv_pkg;

  localparam int CH_W     = 8;    // one color channel
  localparam int PIX_W    = 3 * CH_W;
  localparam int COEF_W   = 16;   // unsigned Q0.16
  localparam int FRAC_W   = 16;
  localparam int CIDX_W   = 5;
  localparam int IMG_W_W  = 12;   // image width register
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 11;
  localparam int NUM_CH   = 3;

  localparam logic [ROW_W-1:0]   ROW_MAX     = '1;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET = 12'd640;

  // request kinds
  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

endpackage

// File: hdl/rgbconv_if.sv
// ----------------------------------------------------------------------------
// rgbconv request and result channels
// Valid/ready channels for the request items and the filtered pixel items.
// ----------------------------------------------------------------------------
interface rgbconv_req_if;
  import rgbconv_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CIDX_W-1:0] coef_index;
  logic [COEF_W-1:0] coef_value;
  logic [CH_W-1:0]   red_in;
  logic [CH_W-1:0]   green_in;
  logic [CH_W-1:0]   blue_in;
  logic              frame_start;

  modport source (
    output valid, req_type, coef_index, coef_value, red_in, green_in, blue_in,
           frame_start,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_value, red_in, green_in, blue_in,
           frame_start,
    output ready
  );
endinterface

interface rgbconv_res_if;
  import rgbconv_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   red_out;
  logic [CH_W-1:0]   green_out;
  logic [CH_W-1:0]   blue_out;
  logic [ROW_W-1:0]  out_row;
  logic [OCOL_W-1:0] out_col;

  modport source (
    output valid, red_out, green_out, blue_out, out_row, out_col,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, out_row, out_col,
    output ready
  );
endinterface

// File: hdl/rgbconv_ram.sv
// ----------------------------------------------------------------------------
// rgbconv_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module rgbconv_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rgb_2d_convolution_valid_core.sv
// ----------------------------------------------------------------------------
// rgb_2d_convolution_valid_core
// Streaming RGB KxK convolution (valid mode) with line buffers in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_i   : request items. req_type selects a coefficient write (coef_index,
//             coef_value) or a pixel (red_in/green_in/blue_in, frame_start).
//             Pixels arrive in raster order; frame_start restarts row/column.
//   res_o   : one filtered item per pixel whose KxK window lies inside the
//             frame, tagged with its row and column in the smaller image.
//   cfg_*   : image width write; always ready, write only while idle.
// Throughput: one request item per clock cycle while no result waits on res_o. The line RAM takes
//   one read and one write per cycle, so a pixel may follow in the next cycle.
// Path: a result reaches res_o through the RAM read, window shift, multiply lanes,
//   row sums and output register after its pixel is accepted.
// Reset: counters, window, coefficient table and pipeline clear; image width
//   returns to 640. The line RAM is not cleared: rows are filled before use.
// Stall: when a result waits and res_o.ready is low, the whole pipeline holds
//   and req_i.ready drops; items that give no result never block the pipe.
// ----------------------------------------------------------------------------
module rgb_2d_convolution_valid_core #(
  parameter int KERNEL_SIZE = 5,
  parameter int MAX_WIDTH   = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rgbconv_pkg::IMG_W_W-1:0] cfg_data_i,
  rgbconv_req_if.sink                 req_i,
  rgbconv_res_if.source               res_o
);
  import rgbconv_pkg::*;

  localparam int LINES   = KERNEL_SIZE - 1;
  localparam int KK      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W   = ((IMG_W_W > WID_W) ? IMG_W_W : WID_W) + 1;
  localparam int LINE_W  = LINES * PIX_W;
  localparam int PROD_W  = CH_W + COEF_W;
  localparam int RSUM_W  = PROD_W + $clog2(KERNEL_SIZE);
  localparam int TSUM_W  = PROD_W + $clog2(KK);

  // --------------------------------------------------------------------------
  // Handshake and configuration
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;        // whole pipeline advances
  logic acc;
  logic acc_pix;

  assign adv         = !out_valid_q || res_o.ready;
  assign req_i.ready = adv;
  assign acc         = req_i.valid && adv;
  assign acc_pix     = acc && (req_i.req_type == REQ_PIXEL);
  assign cfg_ready_o = 1'b1;

  logic [IMG_W_W-1:0] width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_valid_i) begin
      width_q <= cfg_data_i;
    end
  end

  // clamp the register to [KERNEL_SIZE, MAX_WIDTH]
  logic [CMP_W-1:0] eff_w;

  always_comb begin
    eff_w = CMP_W'(width_q);
    if (eff_w < CMP_W'(KERNEL_SIZE)) begin
      eff_w = CMP_W'(KERNEL_SIZE);
    end
    if (eff_w > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: raster position of the incoming pixel
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_q, col_d, cur_col;
  logic [ROW_W-1:0] row_q, row_d, cur_row;
  logic             row_end;
  logic             produce;

  always_comb begin
    cur_col = req_i.frame_start ? '0 : col_q;
    cur_row = req_i.frame_start ? '0 : row_q;
    row_end = (CMP_W'(cur_col) + CMP_W'(1)) >= eff_w;
    col_d   = row_end ? '0 : cur_col + COL_W'(1);
    row_d   = cur_row;
    if (row_end && (cur_row != ROW_MAX)) begin
      row_d = cur_row + ROW_W'(1);
    end
    produce = (cur_row >= ROW_W'(LINES)) && (CMP_W'(cur_col) >= CMP_W'(LINES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_pix) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 registers: item waiting for its line RAM column
  logic              s1_valid_q;
  logic              s1_is_pix_q;
  logic              s1_prod_q;
  pixel_t            s1_pix_q;
  logic [COL_W-1:0]  s1_addr_q;
  logic [ROW_W-1:0]  s1_orow_q;
  logic [OCOL_W-1:0] s1_ocol_q;
  logic [CIDX_W-1:0] s1_cidx_q;
  logic [COEF_W-1:0] s1_cval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_is_pix_q <= 1'b0;
      s1_prod_q   <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= acc;
      s1_is_pix_q <= acc_pix;
      s1_prod_q   <= acc_pix && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= '{red: req_i.red_in, green: req_i.green_in, blue: req_i.blue_in};
      s1_addr_q <= cur_col;
      s1_orow_q <= cur_row - ROW_W'(LINES);
      s1_ocol_q <= OCOL_W'(cur_col - COL_W'(LINES));
      s1_cidx_q <= req_i.coef_index;
      s1_cval_q <= req_i.coef_value;
    end
  end

  // --------------------------------------------------------------------------
  // Line RAM: one word per column holds the LINES earlier rows.
  // Read at accept, write the shifted column back as the pixel leaves stage 1.
  // --------------------------------------------------------------------------
  logic              line_we;
  logic [LINE_W-1:0] line_wdata;
  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] line_col;
  logic              fwd_q;
  logic [LINE_W-1:0] fwd_data_q;
  pixel_t            newcol [KERNEL_SIZE];

  assign line_we = adv && s1_valid_q && s1_is_pix_q;

  rgbconv_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .re_i    (acc_pix),
    .raddr_i (cur_col),
    .rdata_o (line_rdata)
  );

  // a same-column write in the read cycle is missed by the RAM: take it here
  always_comb begin
    line_col = fwd_q ? fwd_data_q : line_rdata;
    for (int i = 0; i < LINES; i++) begin
      newcol[i] = pixel_t'(line_col[i*PIX_W +: PIX_W]);
    end
    newcol[LINES] = s1_pix_q;
    for (int i = 0; i < LINES; i++) begin
      line_wdata[i*PIX_W +: PIX_W] = newcol[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (adv) begin
      fwd_q <= line_we && acc_pix && (cur_col == s1_addr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fwd_data_q <= line_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 work: shift the window, write coefficients
  // --------------------------------------------------------------------------
  pixel_t            win_q  [KERNEL_SIZE][KERNEL_SIZE];
  logic [COEF_W-1:0] coef_q [KK];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          win_q[i][j] <= '0;
        end
      end
      for (int k = 0; k < KK; k++) begin
        coef_q[k] <= '0;
      end
    end else if (adv && s1_valid_q) begin
      if (s1_is_pix_q) begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
          for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
            win_q[i][j] <= win_q[i][j+1];
          end
          win_q[i][KERNEL_SIZE-1] <= newcol[i];
        end
      end else begin
        // out-of-range indexes match no entry and drop
        for (int k = 0; k < KK; k++) begin
          if (int'(s1_cidx_q) == k) begin
            coef_q[k] <= s1_cval_q;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2..4: multiply lanes, row sums, total with saturation
  // --------------------------------------------------------------------------
  logic              p2_valid_q, p3_valid_q, p4_valid_q;
  logic [ROW_W-1:0]  p2_orow_q, p3_orow_q, p4_orow_q;
  logic [OCOL_W-1:0] p2_ocol_q, p3_ocol_q, p4_ocol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else if (adv) begin
      p2_valid_q <= s1_valid_q && s1_prod_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_orow_q <= s1_orow_q;
      p2_ocol_q <= s1_ocol_q;
      p3_orow_q <= p2_orow_q;
      p3_ocol_q <= p2_ocol_q;
      p4_orow_q <= p3_orow_q;
      p4_ocol_q <= p3_ocol_q;
    end
  end

  // channel c sits at bits [(NUM_CH-1-c)*CH_W +: CH_W] of a pixel
  logic [PROD_W-1:0] prod_q [NUM_CH][KERNEL_SIZE][KERNEL_SIZE];
  logic [RSUM_W-1:0] rsum_d [NUM_CH][KERNEL_SIZE];
  logic [RSUM_W-1:0] rsum_q [NUM_CH][KERNEL_SIZE];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        for (int i = 0; i < KERNEL_SIZE; i++) begin
          for (int j = 0; j < KERNEL_SIZE; j++) begin
            prod_q[c][i][j] <= PROD_W'(win_q[i][j][(NUM_CH-1-c)*CH_W +: CH_W])
                               * PROD_W'(coef_q[i*KERNEL_SIZE + j]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        rsum_d[c][i] = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          rsum_d[c][i] = rsum_d[c][i] + RSUM_W'(prod_q[c][i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsum_q <= rsum_d;
    end
  end

  logic [TSUM_W-1:0] tsum [NUM_CH];
  logic [CH_W-1:0]   sat  [NUM_CH];

  // truncate the Q13.16 sum, clip to full scale
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tsum[c] = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        tsum[c] = tsum[c] + TSUM_W'(rsum_q[c][i]);
      end
      if (|tsum[c][TSUM_W-1:FRAC_W+CH_W]) begin
        sat[c] = '1;
      end else begin
        sat[c] = tsum[c][FRAC_W +: CH_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]   out_red_q, out_green_q, out_blue_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [OCOL_W-1:0] out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && p4_valid_q) begin
      out_red_q   <= sat[0];
      out_green_q <= sat[1];
      out_blue_q  <= sat[2];
      out_row_q   <= p4_orow_q;
      out_col_q   <= p4_ocol_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.red_out   = out_red_q;
  assign res_o.green_out = out_green_q;
  assign res_o.blue_out  = out_blue_q;
  assign res_o.out_row   = out_row_q;
  assign res_o.out_col   = out_col_q;

`ifndef SYNTHESIS
  // a waiting result blocks new items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !req_i.ready)
    else $error("request accepted while result stalled");

  // forwarding only serves a pixel waiting for its column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> (s1_valid_q && s1_is_pix_q))
    else $error("line forward without pending pixel");

  // coefficient writes never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_is_pix_q) |-> !s1_prod_q)
    else $error("coefficient write marked as producing");

  // a result enters the output register only from a producing pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !p4_valid_q) |=> !out_valid_q)
    else $error("result without producing pixel");
`endif

endmodule
